/* sv/spg_pkg.sv */
// Shared types, constants and command/status bundles of the step pulse generator.
package spg_pkg;

  // Item opcodes
  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_START    = 2'd1,
    OP_STOP     = 2'd2,
    OP_STOP_ALL = 2'd3
  } op_t;

  // Ramp stages
  typedef enum logic [1:0] {
    STG_ACCEL  = 2'd0,
    STG_CRUISE = 2'd1,
    STG_DECEL  = 2'd2
  } stage_t;

  // Operand sets for the divider lanes
  typedef enum logic [1:0] {
    SRC_TICK   = 2'd0,
    SRC_START1 = 2'd1,
    SRC_START2 = 2'd2
  } div_src_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TICK_LOAD,
    ST_TICK_DIV,
    ST_TICK_EVAL,
    ST_TICK_RAMP,
    ST_S1_LOAD,
    ST_S1_DIV,
    ST_S1_CAP,
    ST_S2_LOAD,
    ST_S2_DIV,
    ST_S2_COMMIT,
    ST_RESULT
  } state_t;

  // Divider geometry: 32-bit dividend covers tick_count, divisors stay below 128
  localparam int NLANES    = 3;
  localparam int DVD_W     = 32;
  localparam int REM_W     = 7;
  localparam int DIV_STEPS = DVD_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [5:0]       SPEED_MAX     = 6'd50;
  localparam logic [15:0]      DELAY_FLOOR   = 16'd20;
  localparam logic [9:0]       PERIOD_RESET  = 10'd1000;
  localparam logic [REM_W-1:0] INTERVAL_IDLE = REM_W'(100);
  localparam logic [REM_W-1:0] UNIT_DIV      = REM_W'(1);
  localparam logic [DVD_W-1:0] INTERVAL_NUM  = DVD_W'(100);
  localparam logic [DVD_W-1:0] DELAY_NUM     = DVD_W'(400);
  localparam logic [DVD_W-1:0] PERIOD_NUM    = DVD_W'(1000);

  // ceil(2^34/5): total * RECIP5 >> 34 is floor(total/5) for any 32-bit total
  localparam logic [31:0]      RECIP5        = 32'hCCCC_CCCD;

  typedef struct packed {
    logic     capture;
    logic     exec;
    logic     div_load;
    logic     div_step;
    div_src_t div_src;
    logic     cap_start;
    logic     commit_start;
    logic     tick_eval;
    logic     tick_ramp;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic busy;
  } sts_t;

endpackage

/* sv/spg_divider.sv */
// Multi-lane restoring divider, one quotient bit per lane per cycle while step is high.
module spg_divider (
  input  logic                                            clk,
  input  logic                                            load,
  input  logic                                            step,
  input  logic [spg_pkg::NLANES-1:0][spg_pkg::DVD_W-1:0] dividend,
  input  logic [spg_pkg::NLANES-1:0][spg_pkg::REM_W-1:0] divisor,
  output logic [spg_pkg::NLANES-1:0][spg_pkg::DVD_W-1:0] quotient,
  output logic [spg_pkg::NLANES-1:0][spg_pkg::REM_W-1:0] remainder
);

  logic [spg_pkg::NLANES-1:0][spg_pkg::DVD_W-1:0] dvd;
  logic [spg_pkg::NLANES-1:0][spg_pkg::REM_W-1:0] dsr;
  logic [spg_pkg::NLANES-1:0][spg_pkg::REM_W-1:0] rem;
  logic [spg_pkg::NLANES-1:0][spg_pkg::REM_W-1:0] rem_next;
  logic [spg_pkg::NLANES-1:0]                     qbit;

  always_comb begin
    for (int l = 0; l < spg_pkg::NLANES; l++) begin
      logic [spg_pkg::REM_W:0] shifted;
      logic [spg_pkg::REM_W:0] diff;
      shifted = {rem[l], dvd[l][spg_pkg::DVD_W-1]};
      diff    = shifted - {1'b0, dsr[l]};
      if (shifted >= {1'b0, dsr[l]}) begin
        qbit[l]     = 1'b1;
        rem_next[l] = diff[spg_pkg::REM_W-1:0];
      end else begin
        qbit[l]     = 1'b0;
        rem_next[l] = shifted[spg_pkg::REM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (step) begin
      for (int l = 0; l < spg_pkg::NLANES; l++) begin
        dvd[l] <= {dvd[l][spg_pkg::DVD_W-2:0], qbit[l]};
      end
      rem <= rem_next;
    end
  end

  assign quotient  = dvd;
  assign remainder = rem;

endmodule

/* sv/spg_datapath.sv */
// Motor state, tick counter, divider operands and output word register.
module spg_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  spg_pkg::cmd_t        cmd,
  output spg_pkg::sts_t        sts,
  input  logic [1:0]           op,
  input  logic                 motor_sel,
  input  logic                 direction,
  input  logic [31:0]          pulse_total,
  input  logic [15:0]          speed_request,
  output logic                 step_a,
  output logic                 step_b,
  output logic                 dir_level,
  output logic                 busy_res,
  output logic                 running_a,
  output logic                 running_b,
  output logic                 start_refused,
  output logic [9:0]           tick_period,
  output logic                 done_a,
  output logic                 done_b,
  output logic [1:0]           stage_a,
  output logic [1:0]           stage_b
);

  // captured item
  spg_pkg::op_t item_op;
  logic         item_sel;
  logic         item_dir;
  logic [31:0]  item_total;
  logic [5:0]   item_speed;
  logic [5:0]   speed_clamp;

  // block state
  logic [31:0]  tick_count;
  logic         dir_reg;
  logic [9:0]   period_reg;
  logic         refused;
  logic [1:0]   run;
  logic [1:0]   step;
  logic [1:0]   pulse;
  logic [1:0]   done;
  logic         busy;

  // per-motor state
  logic [31:0]                pc       [2];
  logic [31:0]                target   [2];
  logic [31:0]                accel    [2];
  logic [32:0]                acsum    [2];
  logic [spg_pkg::REM_W-1:0] interval [2];
  logic [15:0]                delay    [2];
  spg_pkg::stage_t            stage    [2];

  logic [spg_pkg::NLANES-1:0][spg_pkg::DVD_W-1:0] dvd_in;
  logic [spg_pkg::NLANES-1:0][spg_pkg::REM_W-1:0] dsr_in;
  logic [spg_pkg::NLANES-1:0][spg_pkg::DVD_W-1:0] quo;
  logic [spg_pkg::NLANES-1:0][spg_pkg::REM_W-1:0] rem;
  logic [32:0]                                    sum_ac;

  // total/10 and 4*total/5 from one reciprocal multiply by 5
  logic [63:0]  prod5;
  logic [29:0]  q5;
  logic [2:0]   q5_x5;
  logic [2:0]   rem5;
  logic [1:0]   adj5;
  logic [31:0]  accel_item;
  logic [31:0]  cruise_item;

  assign busy     = |run;
  assign sts.busy = busy;
  assign sts.op   = item_op;

  always_comb begin
    if (speed_request == 16'd0) begin
      speed_clamp = 6'd1;
    end else if (speed_request > {10'd0, spg_pkg::SPEED_MAX}) begin
      speed_clamp = spg_pkg::SPEED_MAX;
    end else begin
      speed_clamp = speed_request[5:0];
    end
  end

  // q5 = floor(total/5); total = 5*q5 + r, r in 0..4
  assign prod5      = {32'd0, item_total} * {32'd0, spg_pkg::RECIP5};
  assign q5_x5      = q5[2:0] + {q5[0], 2'b00};
  assign rem5       = item_total[2:0] - q5_x5;
  // floor(4*r/5)
  assign adj5       = (rem5 == 3'd0) ? 2'd0 : 2'(rem5 - 3'd1);
  assign accel_item = {3'b000, q5[29:1]};

  // lane operands
  always_comb begin
    case (cmd.div_src)
      spg_pkg::SRC_START1: begin
        dvd_in[0] = '0;
        dsr_in[0] = spg_pkg::UNIT_DIV;
        dvd_in[1] = '0;
        dsr_in[1] = spg_pkg::UNIT_DIV;
        dvd_in[2] = spg_pkg::INTERVAL_NUM;
        dsr_in[2] = {1'b0, item_speed};
      end
      spg_pkg::SRC_START2: begin
        dvd_in[0] = spg_pkg::DELAY_NUM;
        dsr_in[0] = {1'b0, item_speed};
        dvd_in[1] = spg_pkg::PERIOD_NUM;
        dsr_in[1] = {1'b0, item_speed};
        dvd_in[2] = '0;
        dsr_in[2] = spg_pkg::UNIT_DIV;
      end
      default: begin
        dvd_in[0] = tick_count;
        dsr_in[0] = interval[0];
        dvd_in[1] = tick_count;
        dsr_in[1] = interval[1];
        dvd_in[2] = '0;
        dsr_in[2] = spg_pkg::UNIT_DIV;
      end
    endcase
  end

  spg_divider u_div (
    .clk       (clk),
    .load      (cmd.div_load),
    .step      (cmd.div_step),
    .dividend  (dvd_in),
    .divisor   (dsr_in),
    .quotient  (quo),
    .remainder (rem)
  );

  assign sum_ac = {1'b0, accel_item} + {1'b0, cruise_item};

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      dir_reg    <= 1'b0;
      period_reg <= spg_pkg::PERIOD_RESET;
      refused    <= 1'b0;
      run        <= '0;
      step       <= '0;
      pulse      <= '0;
      done       <= '0;
      for (int m = 0; m < 2; m++) begin
        stage[m]    <= spg_pkg::STG_ACCEL;
        interval[m] <= spg_pkg::INTERVAL_IDLE;
      end
    end else begin
      if (cmd.capture) begin
        refused <= 1'b0;
        done    <= '0;
        pulse   <= '0;
      end
      if (cmd.exec) begin
        case (item_op)
          spg_pkg::OP_TICK: begin
            if (busy) tick_count <= tick_count + 32'd1;
          end
          spg_pkg::OP_START: begin
            if (busy) refused <= 1'b1;
          end
          spg_pkg::OP_STOP: begin
            run[item_sel] <= 1'b0;
          end
          spg_pkg::OP_STOP_ALL: begin
            run <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.cap_start) begin
        interval[item_sel] <= quo[2][spg_pkg::REM_W-1:0];
      end
      if (cmd.commit_start) begin
        dir_reg         <= item_dir;
        period_reg      <= quo[1][9:0];
        run[item_sel]   <= 1'b1;
        step[item_sel]  <= 1'b0;
        stage[item_sel] <= spg_pkg::STG_ACCEL;
      end
      if (cmd.tick_eval) begin
        for (int m = 0; m < 2; m++) begin
          // phase hit: toggle; a high-to-low toggle is one pulse
          pulse[m] <= run[m] && (rem[m] == '0) && step[m];
          if (run[m] && (rem[m] == '0)) step[m] <= !step[m];
        end
      end
      if (cmd.tick_ramp) begin
        for (int m = 0; m < 2; m++) begin
          if (pulse[m]) begin
            case (stage[m])
              spg_pkg::STG_ACCEL: begin
                if (pc[m] >= accel[m]) stage[m] <= spg_pkg::STG_CRUISE;
              end
              spg_pkg::STG_CRUISE: begin
                if ({1'b0, pc[m]} >= acsum[m]) stage[m] <= spg_pkg::STG_DECEL;
              end
              default: ;
            endcase
            if (pc[m] >= target[m]) begin
              run[m]  <= 1'b0;
              done[m] <= 1'b1;
            end
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_op    <= spg_pkg::op_t'(op);
      item_sel   <= motor_sel;
      item_dir   <= direction;
      item_total <= pulse_total;
      item_speed <= speed_clamp;
    end
    // item_total holds through a start, so these settle well before cap_start
    q5          <= prod5[63:34];
    cruise_item <= {q5, 2'b00} + {30'd0, adj5};
    if (cmd.cap_start) begin
      accel[item_sel] <= accel_item;
      acsum[item_sel] <= sum_ac;
    end
    if (cmd.commit_start) begin
      target[item_sel] <= item_total;
      pc[item_sel]     <= '0;
      delay[item_sel]  <= quo[0][15:0];
    end
    if (cmd.tick_eval) begin
      for (int m = 0; m < 2; m++) begin
        if (run[m] && (rem[m] == '0) && step[m]) pc[m] <= pc[m] + 32'd1;
      end
    end
    if (cmd.tick_ramp) begin
      for (int m = 0; m < 2; m++) begin
        if (pulse[m]) begin
          if (stage[m] == spg_pkg::STG_ACCEL) begin
            if ((pc[m] < accel[m]) && (delay[m] > spg_pkg::DELAY_FLOOR)) begin
              delay[m] <= delay[m] - 16'd1;
            end
          end else if (stage[m] == spg_pkg::STG_DECEL) begin
            delay[m] <= delay[m] + 16'd1;
          end
        end
      end
    end
    if (cmd.out_load) begin
      step_a        <= step[0];
      step_b        <= step[1];
      dir_level     <= dir_reg;
      busy_res      <= busy;
      running_a     <= run[0];
      running_b     <= run[1];
      start_refused <= refused;
      tick_period   <= period_reg;
      done_a        <= done[0];
      done_b        <= done[1];
      stage_a       <= stage[0];
      stage_b       <= stage[1];
    end
  end

endmodule

/* sv/spg_ctrl.sv */
// Sequencer: handshakes, item dispatch and divider iteration count.
module spg_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  spg_pkg::sts_t sts,
  output spg_pkg::cmd_t cmd
);

  spg_pkg::state_t          state;
  spg_pkg::state_t          state_next;
  logic [spg_pkg::CNT_W-1:0] div_cnt;
  logic                      div_last;

  assign div_last = (div_cnt == spg_pkg::CNT_W'(spg_pkg::DIV_STEPS - 1));

  always_comb begin
    state_next = state;
    case (state)
      spg_pkg::ST_IDLE: begin
        if (in_valid) state_next = spg_pkg::ST_EXEC;
      end
      spg_pkg::ST_EXEC: begin
        case (sts.op)
          spg_pkg::OP_TICK: begin
            state_next = sts.busy ? spg_pkg::ST_TICK_LOAD : spg_pkg::ST_RESULT;
          end
          spg_pkg::OP_START: begin
            state_next = sts.busy ? spg_pkg::ST_RESULT : spg_pkg::ST_S1_LOAD;
          end
          default: state_next = spg_pkg::ST_RESULT;
        endcase
      end
      spg_pkg::ST_TICK_LOAD: state_next = spg_pkg::ST_TICK_DIV;
      spg_pkg::ST_TICK_DIV: begin
        if (div_last) state_next = spg_pkg::ST_TICK_EVAL;
      end
      spg_pkg::ST_TICK_EVAL: state_next = spg_pkg::ST_TICK_RAMP;
      spg_pkg::ST_TICK_RAMP: state_next = spg_pkg::ST_RESULT;
      spg_pkg::ST_S1_LOAD:   state_next = spg_pkg::ST_S1_DIV;
      spg_pkg::ST_S1_DIV: begin
        if (div_last) state_next = spg_pkg::ST_S1_CAP;
      end
      spg_pkg::ST_S1_CAP:    state_next = spg_pkg::ST_S2_LOAD;
      spg_pkg::ST_S2_LOAD:   state_next = spg_pkg::ST_S2_DIV;
      spg_pkg::ST_S2_DIV: begin
        if (div_last) state_next = spg_pkg::ST_S2_COMMIT;
      end
      spg_pkg::ST_S2_COMMIT: state_next = spg_pkg::ST_RESULT;
      spg_pkg::ST_RESULT: begin
        if (!out_valid || !out_stall) state_next = spg_pkg::ST_IDLE;
      end
      default: state_next = spg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.div_src = spg_pkg::SRC_TICK;
    in_stall    = rst || (state != spg_pkg::ST_IDLE);
    case (state)
      spg_pkg::ST_IDLE:      cmd.capture = in_valid && !rst;
      spg_pkg::ST_EXEC:      cmd.exec = 1'b1;
      spg_pkg::ST_TICK_LOAD: cmd.div_load = 1'b1;
      spg_pkg::ST_S1_LOAD: begin
        cmd.div_load = 1'b1;
        cmd.div_src  = spg_pkg::SRC_START1;
      end
      spg_pkg::ST_S2_LOAD: begin
        cmd.div_load = 1'b1;
        cmd.div_src  = spg_pkg::SRC_START2;
      end
      spg_pkg::ST_TICK_DIV,
      spg_pkg::ST_S1_DIV,
      spg_pkg::ST_S2_DIV:    cmd.div_step = 1'b1;
      spg_pkg::ST_S1_CAP:    cmd.cap_start = 1'b1;
      spg_pkg::ST_S2_COMMIT: cmd.commit_start = 1'b1;
      spg_pkg::ST_TICK_EVAL: cmd.tick_eval = 1'b1;
      spg_pkg::ST_TICK_RAMP: cmd.tick_ramp = 1'b1;
      spg_pkg::ST_RESULT:    cmd.out_load = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= spg_pkg::ST_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.div_load) begin
        div_cnt <= '0;
      end else if (state inside {spg_pkg::ST_TICK_DIV, spg_pkg::ST_S1_DIV,
                                 spg_pkg::ST_S2_DIV}) begin
        div_cnt <= div_cnt + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_accept_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an item is in flight");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("result word loaded but not presented");

  a_result_waits: assert property (@(posedge clk) disable iff (rst)
    (state == spg_pkg::ST_RESULT && out_valid && out_stall) |=>
    (state == spg_pkg::ST_RESULT))
    else $error("result overwrote a word still waiting");
`endif

endmodule

/* sv/stepper_pulse_generator.sv */
// Top level of the two-motor step pulse generator with ramp stages.
//
//  channel | handshake            | word
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_stall  | op, motor_sel, direction, pulse_total,
//          |                      | speed_request
//  out     | out_valid / out_stall| step_a, step_b, dir_level, busy_res,
//          |                      | running_a, running_b, start_refused,
//          |                      | tick_period, done_a, done_b, stage_a, stage_b
//
// Sequencing: one item at a time. A tick while busy runs the 32-step
// restoring divider that forms tick_count mod interval for both motors at
// once. An accepted start makes two divider passes: 100/speed, then 400/speed
// and 1000/speed; total/10 and 4*total/5 come from a reciprocal multiply
// alongside. Idle ticks, refused starts and stops go from dispatch straight
// to the result.
// Reset: synchronous rst clears state to idle, period 1000, all motors stopped;
// the input stalls while rst is high.
// Stalls: the result word sits in an output register; the next input word is
// accepted while it waits, and that item's result holds until the register
// frees up.
module stepper_pulse_generator (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic        motor_sel,
  input  logic        direction,
  input  logic [31:0] pulse_total,
  input  logic [15:0] speed_request,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        step_a,
  output logic        step_b,
  output logic        dir_level,
  output logic        busy_res,
  output logic        running_a,
  output logic        running_b,
  output logic        start_refused,
  output logic [9:0]  tick_period,
  output logic        done_a,
  output logic        done_b,
  output logic [1:0]  stage_a,
  output logic [1:0]  stage_b
);

  // command bundle from the sequencer, status back from the datapath
  spg_pkg::cmd_t cmd;
  spg_pkg::sts_t sts;

  spg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds every motor register, the shared divider and the
  // output word; busy is derived as the OR of the two run flags.
  spg_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .op            (op),
    .motor_sel     (motor_sel),
    .direction     (direction),
    .pulse_total   (pulse_total),
    .speed_request (speed_request),
    .step_a        (step_a),
    .step_b        (step_b),
    .dir_level     (dir_level),
    .busy_res      (busy_res),
    .running_a     (running_a),
    .running_b     (running_b),
    .start_refused (start_refused),
    .tick_period   (tick_period),
    .done_a        (done_a),
    .done_b        (done_b),
    .stage_a       (stage_a),
    .stage_b       (stage_b)
  );

endmodule
